@@ hdl/kmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmsd_pkg: shared types and constants of the key matrix scanner
// Beat layouts for the request and response channels, command codes and
// the default matrix geometry.
// ----------------------------------------------------------------------------
package kmsd_pkg;

   localparam int ROWS_DEFAULT    = 4;
   localparam int COLUMNS_DEFAULT = 8;

   localparam logic [3:0] DEBOUNCE_RESET = 4'd4;

   typedef enum logic {
      CMD_SCAN  = 1'b0,
      CMD_PRIME = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] column_pins;
   } req_type;

   typedef struct packed {
      logic [1:0]  row_index;
      logic [3:0]  row_drive_n;
      logic        changed;
      logic [1:0]  changed_row;
      logic [7:0]  changed_value;
      logic [31:0] board_state;
   } rsp_type;

endpackage

@@ hdl/key_matrix_scan_debounce.sv @@
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce: row-by-row matrix scanner with debounce
// A request beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// single pass from the input register through the row update into the result
// register. Reset (synchronous) clears the stored board, scan row, candidate
// and running check, and sets the debounce setting to 4.
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce #(
   parameter int ROWS    = kmsd_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = kmsd_pkg::COLUMNS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmsd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   localparam int RW = $clog2(ROWS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   logic              in_valid_ff, in_valid_in;
   kmsd_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   kmsd_pkg::rsp_type out_data_ff, out_data_in;

   logic [COLUMNS-1:0] stored_ff [ROWS];
   logic [COLUMNS-1:0] stored_in [ROWS];
   logic [RW-1:0]      scan_row_ff, scan_row_in;
   logic [COLUMNS-1:0] candidate_ff, candidate_in;
   logic [3:0]         confirm_ff, confirm_in;
   logic [3:0]         debounce_ff, debounce_in;

   logic               accept, move;
   logic [COLUMNS-1:0] sample;
   logic [RW-1:0]      row_after;
   logic               chg;
   logic [31:0]        row32, cand32, board;

   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      debounce_in = (csr_valid && csr_ready) ? csr_data : debounce_ff;
   end

   // One scan step on the beat held in the input register
   always_comb begin
      sample       = COLUMNS'(~32'(in_data_ff.column_pins));
      row_after    = (scan_row_ff == LAST_ROW) ? '0 : scan_row_ff + RW'(1);
      stored_in    = stored_ff;
      scan_row_in  = scan_row_ff;
      candidate_in = candidate_ff;
      confirm_in   = confirm_ff;
      chg          = 1'b0;
      if (in_data_ff.cmd == kmsd_pkg::CMD_PRIME) begin
         stored_in[scan_row_ff] = sample;
         confirm_in             = '0;
         scan_row_in            = row_after;
      end else if (confirm_ff != 4'd0) begin
         if (sample != candidate_ff) begin
            confirm_in  = '0;
            scan_row_in = row_after;
         end else begin
            confirm_in = confirm_ff - 4'd1;
            if (confirm_ff == 4'd1) begin
               stored_in[scan_row_ff] = candidate_ff;
               chg                    = 1'b1;
               scan_row_in            = row_after;
            end
         end
      end else begin
         candidate_in = sample;
         if (stored_ff[scan_row_ff] == sample) begin
            scan_row_in = row_after;
         end else begin
            confirm_in = (debounce_ff == 4'd0) ? 4'd1 : debounce_ff;
         end
      end

      board = '0;
      for (int r = 0; r < ROWS; r++) begin
         if (r * COLUMNS < 32) begin
            board = board | (32'(stored_in[r]) << (r * COLUMNS));
         end
      end

      row32  = 32'(scan_row_in);
      cand32 = 32'(candidate_ff);
      out_data_in.row_index     = row32[1:0];
      out_data_in.row_drive_n   = (row32 < 32'd4) ? ~(4'b0001 << row32[1:0]) : 4'hF;
      out_data_in.changed       = chg;
      out_data_in.changed_row   = chg ? 2'(32'(scan_row_ff)) : 2'd0;
      out_data_in.changed_value = chg ? cand32[7:0] : 8'd0;
      out_data_in.board_state   = board;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         scan_row_ff  <= '0;
         candidate_ff <= '0;
         confirm_ff   <= '0;
         debounce_ff  <= kmsd_pkg::DEBOUNCE_RESET;
         for (int r = 0; r < ROWS; r++) begin
            stored_ff[r] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         debounce_ff  <= debounce_in;
         // advance the board only when the step moves to the result register
         if (move) begin
            scan_row_ff  <= scan_row_in;
            candidate_ff <= candidate_in;
            confirm_ff   <= confirm_in;
            stored_ff    <= stored_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= out_data_in;
      end
   end

   // A held beat always reaches an empty result register next cycle
   a_move_to_out: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("request beat not moved to result register");

   // A running check only ever tracks a value that differs from the stored row
   a_check_differs: assert property (@(posedge clock) disable iff (reset)
      (confirm_ff != 4'd0) |-> (candidate_ff != stored_ff[scan_row_ff]))
      else $error("debounce check running on an unchanged row");

   // At most one row is driven low
   a_drive_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($countones(~out_data_ff.row_drive_n) <= 1))
      else $error("more than one row driven");

endmodule

@@ test/key_matrix_scan_debounce_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce_tb: self-checking bench for the matrix scanner
// Drives scan and prime beats that emulate a keypad with bouncing keys, keeps
// a cycle-free model of the row scan and debounce check, and compares every
// response beat field by field. Traffic runs with random sender bursts and
// receiver stalls across several debounce settings.
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce_tb;

   localparam int ROWS        = kmsd_pkg::ROWS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   kmsd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   kmsd_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [3:0]        csr_data = '0;

   // scanner model
   logic [7:0] board_rows [ROWS];
   logic [1:0] scan_row;
   logic [7:0] candidate;
   logic [3:0] confirm_left;
   logic [3:0] debounce_setting;

   // emulated keypad: bit set = key held down
   logic [7:0] keys_down [ROWS];
   int         bounce_left [ROWS];

   kmsd_pkg::rsp_type expected_reports [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         stall_pct = 0;
   int         stall_run = 0;
   int         hold_requests = 0;
   int         holds_served = 0;
   int         hold_left = 0;

   key_matrix_scan_debounce DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall runs, plus a long hold-off on request
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         stall_run <= $urandom_range(6);
      end
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %0h, got %0h", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      kmsd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response beat with none expected: %0h", $realtime, rsp_data);
         end else begin
            want = expected_reports.pop_front();
            check_field("row_index", 32'(want.row_index), 32'(rsp_data.row_index));
            check_field("row_drive_n", 32'(want.row_drive_n), 32'(rsp_data.row_drive_n));
            check_field("changed", 32'(want.changed), 32'(rsp_data.changed));
            check_field("changed_row", 32'(want.changed_row), 32'(rsp_data.changed_row));
            check_field("changed_value", 32'(want.changed_value),
                        32'(rsp_data.changed_value));
            check_field("board_state", want.board_state, rsp_data.board_state);
         end
      end
   end

   // advance the model by one accepted beat and return the report it gives
   function automatic kmsd_pkg::rsp_type next_scan_report(kmsd_pkg::req_type beat);
      kmsd_pkg::rsp_type report;
      logic [7:0]        sample;
      logic [1:0]        row;
      report = '0;
      sample = ~beat.column_pins;
      row    = scan_row;
      if (beat.cmd == kmsd_pkg::CMD_PRIME) begin
         board_rows[row] = sample;
         confirm_left    = '0;
         scan_row        = scan_row + 2'd1;
      end else if (confirm_left != 0) begin
         if (sample != candidate) begin
            confirm_left = '0;
            scan_row     = scan_row + 2'd1;
         end else begin
            confirm_left = confirm_left - 4'd1;
            if (confirm_left == 0) begin
               board_rows[row]      = candidate;
               report.changed       = 1'b1;
               report.changed_row   = row;
               report.changed_value = candidate;
               scan_row             = scan_row + 2'd1;
            end
         end
      end else begin
         candidate = sample;
         if (board_rows[row] == sample)
            scan_row = scan_row + 2'd1;
         else
            confirm_left = (debounce_setting == 0) ? 4'd1 : debounce_setting;
      end
      report.row_index   = scan_row;
      report.row_drive_n = ~(4'b0001 << scan_row);
      report.board_state = {board_rows[3], board_rows[2], board_rows[1], board_rows[0]};
      return report;
   endfunction

   task automatic send_beat(kmsd_pkg::req_type beat);
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_reports.push_back(next_scan_report(beat));
   endtask

   task automatic send_scan(logic [7:0] pins);
      send_beat('{cmd: kmsd_pkg::CMD_SCAN, column_pins: pins});
   endtask

   task automatic send_prime(logic [7:0] pins);
      send_beat('{cmd: kmsd_pkg::CMD_PRIME, column_pins: pins});
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(logic [3:0] value);
      wait_drain();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      debounce_setting = value;
   endtask

   // mostly clean keypad samples for the row being scanned, with key changes
   // that bounce for a few scans, some noise and some prime beats
   function automatic kmsd_pkg::req_type next_keypad_beat();
      kmsd_pkg::req_type beat;
      int                row;
      int                pick;
      if ($urandom_range(99) < 8) begin
         row                 = $urandom_range(ROWS - 1);
         keys_down[row]      = keys_down[row] ^ (8'h01 << $urandom_range(7));
         bounce_left[row]    = $urandom_range(3);
      end
      beat.cmd         = kmsd_pkg::CMD_SCAN;
      beat.column_pins = ~keys_down[scan_row];
      if (bounce_left[scan_row] != 0) begin
         bounce_left[scan_row]--;
         if ($urandom_range(1) != 0)
            beat.column_pins = beat.column_pins ^ (8'h01 << $urandom_range(7));
      end
      pick = $urandom_range(99);
      if (pick < 3)
         beat.cmd = kmsd_pkg::CMD_PRIME;
      else if (pick < 8)
         beat.column_pins = 8'($urandom);
      return beat;
   endfunction

   task automatic send_traffic(int count, int gap_max);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(24, 1);
         while (burst != 0 && sent < count) begin
            send_beat(next_keypad_beat());
            burst--;
            sent++;
         end
         if (gap_max != 0) begin
            burst = $urandom_range(gap_max);
            if (burst != 0) begin
               req_valid <= 1'b0;
               repeat (burst) @(posedge clock);
            end
         end
      end
   endtask

   task automatic test_directed_cases();
      stall_pct = 0;
      // prime every row, wrapping back to row 0
      send_prime(8'h00);
      send_prime(8'hFF);
      send_prime(8'h55);
      send_prime(8'hAA);
      // unchanged row advances at once
      send_scan(8'h00);
      // changed row held for the reset setting of four confirming scans
      repeat (5) send_scan(8'h7E);
      // mismatch during the check drops it
      send_scan(8'h00);
      send_scan(8'h01);
      // prime during a check stores directly
      send_scan(8'hFF);
      send_prime(8'h0F);
      // setting zero behaves as one
      write_debounce(4'd0);
      send_scan(8'hFF);
      send_scan(8'hFF);
      write_debounce(4'd1);
      send_scan(8'h80);
      send_scan(8'h80);
   endtask

   task automatic test_random_setting(logic [3:0] setting, int count, int gap_max,
                                      int stall_level);
      write_debounce(setting);
      stall_pct = stall_level;
      send_traffic(count, gap_max);
   endtask

   task automatic test_backpressure();
      wait_drain();
      stall_pct = 0;
      @(posedge clock);
      hold_requests <= hold_requests + 1;
      send_traffic(150, 0);
   endtask

   task automatic test_sender_pause();
      stall_pct = 25;
      send_traffic(20, 3);
      wait_drain();
      send_traffic(20, 3);
   endtask

   initial begin
      for (int r = 0; r < ROWS; r++) begin
         board_rows[r]  = '0;
         keys_down[r]   = '0;
         bounce_left[r] = 0;
      end
      scan_row         = '0;
      candidate        = '0;
      confirm_left     = '0;
      debounce_setting = kmsd_pkg::DEBOUNCE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_setting(4'd1, 250, 3, 20);
      test_random_setting(4'd15, 250, 0, 0);
      test_random_setting(4'd7, 250, 8, 50);
      test_random_setting(4'd0, 250, 2, 10);
      test_random_setting(4'd4, 250, 5, 30);
      test_random_setting(4'($urandom_range(14, 1)), 250, 4, 25);
      test_backpressure();
      test_sender_pause();

      wait_drain();
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
